[rtl/crt_pkg.sv]
// Shared types and codes for the connection route table.
package crt_pkg;

  // Operation codes carried on the request side.
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_GET = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_OVERWRITE = 3'd1;
  localparam logic [2:0] ST_EVICTED   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;
  localparam logic [2:0] ST_MISS      = 3'd5;

  // Field widths.
  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int ORDER_W = 16;
  localparam int LIMIT_W = 7;
  localparam int STAT_W  = 3;

  // Reset value of the per-source limit.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // One stored route.
  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  src_addr;
    logic [PORT_W-1:0]  src_port;
    logic [ADDR_W-1:0]  dst_addr;
    logic [PORT_W-1:0]  dst_port;
    logic [ORDER_W-1:0] order;
  } entry_t;

endpackage

[rtl/connection_route_table.sv]
// Connection route table: flow table keyed by source address and port.
//
// Requests arrive on the s_ channel: s_tuser holds the operation (add or get) and
// s_tdata the key and the destination to store. Every request gives exactly one
// result on the m_ channel: m_tuser holds the status and m_tdata the route found.
// The user must write the per-source limit through cfg_wr_en and cfg_wr_data while
// the block is idle (not enforced); it then takes effect from the next request.
//
// Each request is handled by a sequencer that reads the table memory one entry a
// cycle through its single read port, collecting the key match, the first free
// slot, the source's entry count and its oldest entry, then does at most one write.
// After acceptance the sequencer passes through S_SCAN, S_TAIL and S_DECIDE, where
// the result is registered, and returns to S_IDLE to take the next request;
// s_tready is high only while no request is in hand.
// The result waits in an output register; a stalled receiver holds it there
// and the next request can still be accepted and scanned meanwhile, but its
// write and result wait until the held result has been taken.
// After reset the table memory is cleared entry by entry in S_CLEAR, during which
// s_tready stays low; configuration writes are taken as ever.
module connection_route_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // src_addr[31:0], src_port[47:32], dst_addr[79:48],
                                 // dst_port[95:80]
  input  logic        s_tuser,   // cmd
  // Result channel.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // route_addr[31:0], route_port[47:32]
  output logic [2:0]  m_tuser,   // status
  // Configuration port.
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data  // per_source_limit
);
  import crt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_TAIL   = 5'b01000,
    S_DECIDE = 5'b10000
  } state_t;

  state_t state, state_next;

  // Configuration and global state.
  logic [LIMIT_W-1:0] per_source_limit;
  logic [ORDER_W-1:0] insert_counter;

  // Latched request.
  logic              req_cmd;
  logic [ADDR_W-1:0] req_src_addr;
  logic [PORT_W-1:0] req_src_port;
  logic [ADDR_W-1:0] req_dst_addr;
  logic [PORT_W-1:0] req_dst_port;

  // Sweep counter and read pipeline tracking.
  logic [IDX_W-1:0] idx;
  logic             p_valid;
  logic [IDX_W-1:0] p_idx;

  // Table memory.
  entry_t           mem [TABLE_ENTRIES];
  entry_t           rd_data;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  // Scan results.
  logic               match_found;
  logic [IDX_W-1:0]   match_idx;
  logic [ADDR_W-1:0]  match_dst_addr;
  logic [PORT_W-1:0]  match_dst_port;
  logic [ORDER_W-1:0] match_order;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [CNT_W-1:0]   src_count;
  logic               old_found;
  logic [IDX_W-1:0]   old_idx;
  logic [ORDER_W-1:0] old_age;

  // Output register.
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [ADDR_W-1:0] out_addr;
  logic [PORT_W-1:0] out_port;

  logic               accept;
  logic               fire;
  logic [ORDER_W-1:0] cur_age;
  logic [LIMIT_W-1:0] limit_eff;
  logic               at_limit;
  logic               bump_counter;
  logic [STAT_W-1:0]  res_status;
  logic [ADDR_W-1:0]  res_addr;
  logic [PORT_W-1:0]  res_port;
  entry_t             new_entry;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign fire     = (state == S_DECIDE) && (!out_valid || m_tready);

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {out_port, out_addr};

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      per_source_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      per_source_limit <= cfg_wr_data;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (idx == LAST_IDX) state_next = S_IDLE;
      S_IDLE:   if (accept) state_next = S_SCAN;
      S_SCAN:   if (idx == LAST_IDX) state_next = S_TAIL;
      S_TAIL:   state_next = S_DECIDE;
      S_DECIDE: if (fire) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR || state == S_SCAN) begin
        idx <= (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
      end else if (accept) begin
        idx <= '0;
      end
    end
  end

  // Read data for the entry issued in the previous cycle is checked now.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= (state == S_SCAN);
    end
    p_idx <= idx;
  end

  // Latch the request on acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd      <= s_tuser;
      req_src_addr <= s_tdata[31:0];
      req_src_port <= s_tdata[47:32];
      req_dst_addr <= s_tdata[79:48];
      req_dst_port <= s_tdata[95:80];
    end
  end

  // Age of the entry being checked, relative to the insert counter.
  assign cur_age = insert_counter - rd_data.order;

  // Scan accumulators: first match, first free slot, count and oldest entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
      old_found   <= 1'b0;
      src_count   <= '0;
    end else if (accept) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
      old_found   <= 1'b0;
      src_count   <= '0;
    end else if (p_valid) begin
      if (!rd_data.valid) begin
        if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= p_idx;
        end
      end else if (rd_data.src_addr == req_src_addr) begin
        src_count <= src_count + CNT_W'(1);
        if (rd_data.src_port == req_src_port && !match_found) begin
          match_found    <= 1'b1;
          match_idx      <= p_idx;
          match_dst_addr <= rd_data.dst_addr;
          match_dst_port <= rd_data.dst_port;
          match_order    <= rd_data.order;
        end
        if (!old_found || cur_age > old_age) begin
          old_found <= 1'b1;
          old_idx   <= p_idx;
          old_age   <= cur_age;
        end
      end
    end
  end

  // Decision on the collected scan results.
  assign limit_eff = (per_source_limit == '0) ? LIMIT_W'(1) : per_source_limit;
  assign at_limit  = CMP_W'(src_count) >= CMP_W'(limit_eff);

  always_comb begin
    new_entry.valid    = 1'b1;
    new_entry.src_addr = req_src_addr;
    new_entry.src_port = req_src_port;
    new_entry.dst_addr = req_dst_addr;
    new_entry.dst_port = req_dst_port;
    new_entry.order    = insert_counter;

    mem_we       = 1'b0;
    mem_waddr    = idx;
    mem_wdata    = new_entry;
    bump_counter = 1'b0;
    res_status   = ST_MISS;
    res_addr     = '0;
    res_port     = '0;

    if (state == S_CLEAR) begin
      mem_we          = 1'b1;
      mem_wdata.valid = 1'b0;
    end else if (fire) begin
      if (req_cmd == CMD_ADD) begin
        if (match_found) begin
          // Same key: new destination, the entry keeps its age.
          mem_we          = 1'b1;
          mem_waddr       = match_idx;
          mem_wdata.order = match_order;
          res_status      = ST_OVERWRITE;
        end else if (at_limit && old_found) begin
          mem_we       = 1'b1;
          mem_waddr    = old_idx;
          bump_counter = 1'b1;
          res_status   = ST_EVICTED;
        end else if (free_found) begin
          mem_we       = 1'b1;
          mem_waddr    = free_idx;
          bump_counter = 1'b1;
          res_status   = ST_ADDED;
        end else begin
          res_status = ST_FULL;
        end
      end else begin
        if (match_found) begin
          // Remove the entry; a zero destination reads as not found.
          mem_we          = 1'b1;
          mem_waddr       = match_idx;
          mem_wdata.valid = 1'b0;
          if (match_dst_addr != '0) begin
            res_status = ST_FOUND;
            res_addr   = match_dst_addr;
            res_port   = match_dst_port;
          end
        end
      end
    end
  end

  // Insertion stamp counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      insert_counter <= '0;
    end else if (bump_counter) begin
      insert_counter <= insert_counter + ORDER_W'(1);
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[idx];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      out_status <= res_status;
      out_addr   <= res_addr;
      out_port   <= res_port;
    end
  end

endmodule

[rtl/crt_check.sv]
// Port-level checks for the connection route table, bound to the top level.
module crt_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [2:0]  m_tuser
);
  import crt_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // A request starts a scan, so the block is busy in the following cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted during a scan");

  // Only defined status codes appear.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= ST_MISS))
    else $error("undefined status code");

  // A route is reported only with the found status.
  a_route_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_FOUND) |-> (m_tdata == 48'd0))
    else $error("route reported without a hit");

  // A found route never has a zero destination address.
  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_FOUND) |-> (m_tdata[31:0] != 32'd0))
    else $error("found status with zero destination");

endmodule

bind connection_route_table crt_check u_crt_check (.*);
